>>> rtl/nfpi_pkg.sv
package nfpi_pkg;

	localparam int NPTS      = 4;
	localparam int DIV_STEPS = 32;
	// lane latency: operand stage, multiply stage, divider (compare, 32 steps, saturate)
	localparam int LANE_LAT  = 2 + DIV_STEPS + 2;

	typedef struct packed {
		logic [NPTS-1:0][31:0] xs;
		logic [31:0]           qx;
		logic [NPTS-1:0][31:0] c;
		logic [NPTS-1:0][31:0] d;
		logic [1:0]            ns;
		logic [31:0]           y;
		logic [31:0]           dy;
		logic                  flag;
	} tab_t;

	typedef struct packed {
		logic [31:0] c;
		logic [31:0] d;
		logic        skip;
	} lane_res_t;

	typedef struct packed {
		logic [31:0] interp_value;
		logic [31:0] error_estimate;
		logic        coincident_flag;
	} res_t;

	function automatic logic [31:0] mag33(logic [32:0] v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic [31:0] sat33(logic [32:0] v);
		if (v[32] != v[31])
			return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return v[31:0];
	endfunction

	function automatic logic [32:0] sx33(logic [31:0] v);
		return {v[31], v};
	endfunction

endpackage

>>> rtl/nfpi_sample_if.sv
interface nfpi_sample_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] x_first;
	logic signed [31:0] x_second;
	logic signed [31:0] x_third;
	logic signed [31:0] x_fourth;
	logic signed [31:0] y_first;
	logic signed [31:0] y_second;
	logic signed [31:0] y_third;
	logic signed [31:0] y_fourth;
	logic signed [31:0] query_x;

	modport source (output valid, x_first, x_second, x_third, x_fourth,
		y_first, y_second, y_third, y_fourth, query_x, input ready);
	modport sink (input valid, x_first, x_second, x_third, x_fourth,
		y_first, y_second, y_third, y_fourth, query_x, output ready);
endinterface

>>> rtl/nfpi_result_if.sv
interface nfpi_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] interp_value;
	logic signed [31:0] error_estimate;
	logic               coincident_flag;

	modport source (output valid, interp_value, error_estimate, coincident_flag,
		input ready);
	modport sink (input valid, interp_value, error_estimate, coincident_flag,
		output ready);
endinterface

>>> rtl/nfpi_div.sv
module nfpi_div import nfpi_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] prod,
	input  logic [31:0] divisor,
	input  logic        neg,
	output logic [31:0] quo
);
	logic [31:0] rem_s [DIV_STEPS+1];
	logic [31:0] low_s [DIV_STEPS+1];
	logic [31:0] q_s   [DIV_STEPS+1];
	logic [31:0] ud_s  [DIV_STEPS+1];
	logic        big_s [DIV_STEPS+1];
	logic        neg_s [DIV_STEPS+1];
	logic [31:0] quo_q;

	// quotient of 2^32 or more saturates; otherwise the high half seeds the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= prod[63:32];
			low_s[0] <= prod[31:0];
			q_s[0]   <= '0;
			ud_s[0]  <= divisor;
			big_s[0] <= prod[63:32] >= divisor;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;
		assign trial = {rem_s[k], low_s[k][31]};
		assign diff  = trial - {1'b0, ud_s[k]};
		assign ge    = trial >= {1'b0, ud_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[31:0] : trial[31:0];
				low_s[k+1] <= {low_s[k][30:0], 1'b0};
				q_s[k+1]   <= {q_s[k][30:0], ge};
				ud_s[k+1]  <= ud_s[k];
				big_s[k+1] <= big_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[DIV_STEPS]) begin
				if (big_s[DIV_STEPS] || q_s[DIV_STEPS] > 32'h8000_0000)
					quo_q <= 32'h8000_0000;
				else
					quo_q <= -q_s[DIV_STEPS];
			end else begin
				if (big_s[DIV_STEPS] || q_s[DIV_STEPS][31])
					quo_q <= 32'h7FFF_FFFF;
				else
					quo_q <= q_s[DIV_STEPS];
			end
		end
	end

	assign quo = quo_q;
endmodule

>>> rtl/nfpi_lane.sv
module nfpi_lane import nfpi_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x_lo,
	input  logic [31:0] x_hi,
	input  logic [31:0] qx,
	input  logic [31:0] c_next,
	input  logic [31:0] d_here,
	output lane_res_t   res
);
	logic [32:0] ho, hp, den, w;
	logic        skip;

	logic [31:0] mho_s1, mhp_s1, mw_s1, ud_s1;
	logic        negc_s1, negd_s1;
	logic [63:0] pc_s2, pd_s2;
	logic [31:0] ud_s2;
	logic        negc_s2, negd_s2;
	logic [LANE_LAT-1:0] skip_q;
	logic [31:0] c_new, d_new;

	assign ho   = sx33(x_lo) - sx33(qx);
	assign hp   = sx33(x_hi) - sx33(qx);
	assign den  = sx33(x_lo) - sx33(x_hi);
	assign w    = sx33(c_next) - sx33(d_here);
	assign skip = den == '0;

	// all magnitudes stay below 2^32
	always_ff @(posedge clk) begin
		if (en) begin
			mho_s1  <= mag33(ho);
			mhp_s1  <= mag33(hp);
			mw_s1   <= mag33(w);
			ud_s1   <= mag33(den);
			negc_s1 <= ho[32] ^ w[32] ^ den[32];
			negd_s1 <= hp[32] ^ w[32] ^ den[32];
			skip_q  <= {skip_q[LANE_LAT-2:0], skip};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s2   <= 64'(mho_s1) * 64'(mw_s1);
			pd_s2   <= 64'(mhp_s1) * 64'(mw_s1);
			ud_s2   <= ud_s1;
			negc_s2 <= negc_s1;
			negd_s2 <= negd_s1;
		end
	end

	nfpi_div u_div_c (.clk(clk), .en(en), .prod(pc_s2), .divisor(ud_s2),
		.neg(negc_s2), .quo(c_new));
	nfpi_div u_div_d (.clk(clk), .en(en), .prod(pd_s2), .divisor(ud_s2),
		.neg(negd_s2), .quo(d_new));

	assign res.c    = c_new;
	assign res.d    = d_new;
	assign res.skip = skip_q[LANE_LAT-1];
endmodule

>>> rtl/nfpi_level.sv
module nfpi_level import nfpi_pkg::*; #(
	parameter int M = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  tab_t tab_in,
	output logic out_valid,
	output tab_t tab_out
);
	localparam int LANES = NPTS - M;

	lane_res_t res [LANES];
	tab_t      side_q [LANE_LAT];
	logic [LANE_LAT-1:0] vld_q;
	tab_t      nxt;
	logic [32:0] sum;
	tab_t      merge_q;
	logic      out_vld_q;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		nfpi_lane u_lane (
			.clk(clk), .en(en),
			.x_lo(tab_in.xs[i]), .x_hi(tab_in.xs[i+M]), .qx(tab_in.qx),
			.c_next(tab_in.c[i+1]), .d_here(tab_in.d[i]),
			.res(res[i])
		);
	end

	// carry the tableau alongside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= tab_in;
			for (int k = 1; k < LANE_LAT; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LANE_LAT-2:0], in_valid};
			out_vld_q <= vld_q[LANE_LAT-1];
		end
	end

	// merge: a zero denominator keeps the old entries and raises the flag
	always_comb begin
		nxt = side_q[LANE_LAT-1];
		for (int i = 0; i < LANES; i++) begin
			if (!res[i].skip) begin
				nxt.c[i] = res[i].c;
				nxt.d[i] = res[i].d;
			end else begin
				nxt.flag = 1'b1;
			end
		end
		if ({nxt.ns, 1'b0} < 3'(LANES)) begin
			nxt.dy = nxt.c[nxt.ns];
		end else begin
			nxt.dy = nxt.d[nxt.ns - 2'd1];
			nxt.ns = nxt.ns - 2'd1;
		end
		sum   = sx33(nxt.y) + sx33(nxt.dy);
		nxt.y = sat33(sum);
	end

	always_ff @(posedge clk) begin
		if (en)
			merge_q <= nxt;
	end

	assign tab_out   = merge_q;
	assign out_valid = out_vld_q;
endmodule

>>> rtl/neville_four_point_interpolator.sv
// Four-point Neville interpolator, signed Q16.16.
//
// sample (valid/ready) carries four (x, y) points and query_x; result
// (valid/ready) returns interp_value, error_estimate and coincident_flag,
// one result per item, in order.
//
// Throughput: one item per cycle while the output buffer has room. From accept
// to result: front stages (capture, distance, nearest-sample select), then 3
// tableau levels (each: operand stage, 32x32 multiply, 32-step restoring
// divider with compare and saturate stages, merge), then the output buffer.
// The per-bit divider pipeline sets the latency.
//
// The pipeline advances as a whole while the two-entry output buffer has
// room, so one finished item can wait at the output while new items are
// still taken. With the buffer full, sample.ready drops and every stage holds.
//
// Reset clears the valid bits and the output buffer; no item is in flight
// after reset.
module neville_four_point_interpolator import nfpi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	nfpi_sample_if.sink  sample,
	nfpi_result_if.source result
);
	logic        en;
	logic        push, pop;

	tab_t        tab_s0, tab_s1, tab_s2;
	logic        vld_s0, vld_s1, vld_s2;
	logic [NPTS-1:0][31:0] dist_s1;
	logic [31:0] best;
	logic [1:0]  ns_c;
	tab_t        tab_sel;

	tab_t        tab_l [NPTS];
	logic        vld_l [NPTS];

	res_t        buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	res_t        head;

	// advance everything while the output buffer has room
	assign en           = cnt_q != 2'd2;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s0 <= sample.valid;
			vld_s1 <= vld_s0;
			vld_s2 <= vld_s1;
		end
	end

	// capture: c and d both start as the ordinates
	always_ff @(posedge clk) begin
		if (en) begin
			tab_s0.xs   <= {sample.x_fourth, sample.x_third, sample.x_second, sample.x_first};
			tab_s0.c    <= {sample.y_fourth, sample.y_third, sample.y_second, sample.y_first};
			tab_s0.d    <= {sample.y_fourth, sample.y_third, sample.y_second, sample.y_first};
			tab_s0.qx   <= sample.query_x;
			tab_s0.ns   <= '0;
			tab_s0.y    <= '0;
			tab_s0.dy   <= '0;
			tab_s0.flag <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tab_s1 <= tab_s0;
			for (int i = 0; i < NPTS; i++)
				dist_s1[i] <= mag33(sx33(tab_s0.qx) - sx33(tab_s0.xs[i]));
		end
	end

	// nearest sample; strict compare keeps the lowest index on a tie
	always_comb begin
		best = dist_s1[0];
		ns_c = '0;
		for (int i = 1; i < NPTS; i++) begin
			if (dist_s1[i] < best) begin
				best = dist_s1[i];
				ns_c = 2'(i);
			end
		end
		tab_sel    = tab_s1;
		tab_sel.ns = ns_c;
		tab_sel.y  = tab_s1.c[ns_c];
	end

	always_ff @(posedge clk) begin
		if (en)
			tab_s2 <= tab_sel;
	end

	assign tab_l[0] = tab_s2;
	assign vld_l[0] = vld_s2;

	for (genvar m = 1; m < NPTS; m++) begin : g_level
		nfpi_level #(.M(m)) u_level (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(vld_l[m-1]), .tab_in(tab_l[m-1]),
			.out_valid(vld_l[m]), .tab_out(tab_l[m])
		);
	end

	// output buffer: two entries let a waiting result not block the input
	assign push = en && vld_l[NPTS-1];
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q].interp_value    <= tab_l[NPTS-1].y;
			buf_q[wr_ptr_q].error_estimate  <= tab_l[NPTS-1].dy;
			buf_q[wr_ptr_q].coincident_flag <= tab_l[NPTS-1].flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	assign head                   = buf_q[rd_ptr_q];
	assign result.valid           = cnt_q != 2'd0;
	assign result.interp_value    = head.interp_value;
	assign result.error_estimate  = head.error_estimate;
	assign result.coincident_flag = head.coincident_flag;

	// buffer never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != 2'd2)
		else $error("output buffer overflow");

	// a result is only taken when one is held
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0)
		else $error("output buffer underflow");

	// an accepted item enters the capture stage
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> vld_s0)
		else $error("accepted item lost at capture");
endmodule

>>> tb/neville_four_point_interpolator_tb.sv
module neville_four_point_interpolator_tb;
	import nfpi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1430;
	localparam int IDLE_LIMIT = 2000;  // cycles with no item moving on either side
	localparam int DRAIN_WAIT = 130;   // idle cycles after the last result before finishing

	typedef struct {
		logic [31:0] x [4];
		logic [31:0] y [4];
		logic [31:0] q;
	} point_set_t;

	typedef struct {
		point_set_t pts;
		bit         known;  // expected result typed in below
		res_t       res;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nfpi_sample_if sample ();
	nfpi_result_if result ();

	neville_four_point_interpolator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source)
	);

	always #5 clk = ~clk;

	res_t expected_q [$];
	int   errors = 0;
	int   idle_cycles = 0;

	// sat(trunc(a * b / den)) on the exact product
	function automatic longint scaled_quotient(longint a, longint b, longint den);
		logic signed [127:0] wa, wb, wd, quot;
		wa = a;
		wb = b;
		wd = den;
		quot = (wa * wb) / wd;
		if (quot > 128'sd2147483647)
			return 64'sd2147483647;
		if (quot < -128'sd2147483648)
			return -64'sd2147483648;
		return longint'(quot);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Neville tableau, starting from the nearest sample
	function automatic res_t interpolate(point_set_t p);
		longint xs [4];
		longint c [4];
		longint d [4];
		longint qx, val, corr, best, sep, ho, hp, den, w;
		int     ns;
		bit     skipped;
		res_t   r;
		qx = longint'($signed(p.q));
		for (int i = 0; i < 4; i++) begin
			xs[i] = longint'($signed(p.x[i]));
			c[i]  = longint'($signed(p.y[i]));
			d[i]  = c[i];
		end
		ns = 0;
		best = (qx > xs[0]) ? qx - xs[0] : xs[0] - qx;
		for (int i = 1; i < 4; i++) begin
			sep = (qx > xs[i]) ? qx - xs[i] : xs[i] - qx;
			// strict compare: ties keep the lowest index
			if (sep < best) begin
				best = sep;
				ns = i;
			end
		end
		val = c[ns];
		corr = 0;
		skipped = 1'b0;
		for (int m = 1; m < 4; m++) begin
			for (int i = 0; i < 4 - m; i++) begin
				ho = xs[i] - qx;
				hp = xs[i + m] - qx;
				den = ho - hp;
				// coincident abscissas: hold the old entries
				if (den == 0) begin
					skipped = 1'b1;
				end else begin
					w = c[i + 1] - d[i];
					d[i] = scaled_quotient(hp, w, den);
					c[i] = scaled_quotient(ho, w, den);
				end
			end
			if (2 * ns < 4 - m) begin
				corr = c[ns];
			end else begin
				corr = d[ns - 1];
				ns--;
			end
			val = clamp32(val + corr);
		end
		r.interp_value    = val[31:0];
		r.error_estimate  = corr[31:0];
		r.coincident_flag = skipped;
		return r;
	endfunction

	function automatic vector_t row(logic [31:0] x0, logic [31:0] x1, logic [31:0] x2,
			logic [31:0] x3, logic [31:0] y0, logic [31:0] y1, logic [31:0] y2,
			logic [31:0] y3, logic [31:0] q, bit known = 1'b0, res_t res = '0);
		vector_t v;
		v.pts.x[0] = x0; v.pts.x[1] = x1; v.pts.x[2] = x2; v.pts.x[3] = x3;
		v.pts.y[0] = y0; v.pts.y[1] = y1; v.pts.y[2] = y2; v.pts.y[3] = y3;
		v.pts.q = q;
		v.known = known;
		v.res = res;
		return v;
	endfunction

	function automatic point_set_t random_set();
		point_set_t p;
		logic [31:0] base, step;
		logic [31:0] ext [4];
		int kind;
		ext[0] = 32'h8000_0000; ext[1] = 32'h7FFF_FFFF; ext[2] = 32'h0; ext[3] = 32'hFFFF_FFFF;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			p.x[i] = $urandom;
			p.y[i] = $urandom;
		end
		p.q = $urandom;
		if (kind >= 2) begin
			// well-formed: ordered abscissas, modest ordinates, query near the samples
			base = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
			for (int i = 0; i < 4; i++) begin
				step = $urandom_range(1, 32'h0004_0000);
				base = base + step;
				p.x[i] = base;
				p.y[i] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			end
			p.q = p.x[0] + $urandom_range(0, 32'h000C_0000) - 32'h0002_0000;
			case (kind)
				7: p.x[$urandom_range(1, 3)] = p.x[$urandom_range(0, 3)];
				8: begin
					// exact midpoint between two neighbors: nearest-sample tie
					int k;
					k = $urandom_range(0, 2);
					p.x[k + 1] = p.x[k] + 2 * $urandom_range(1, 32'h0002_0000);
					p.q = p.x[k] + (p.x[k + 1] - p.x[k]) / 2;
				end
				9: for (int i = 0; i < 4; i++) p.y[i] = ext[$urandom_range(0, 3)];
				default: ;
			endcase
		end
		return p;
	endfunction

	task automatic drive(point_set_t p);
		sample.valid    <= 1'b1;
		sample.x_first  <= p.x[0];
		sample.x_second <= p.x[1];
		sample.x_third  <= p.x[2];
		sample.x_fourth <= p.x[3];
		sample.y_first  <= p.y[0];
		sample.y_second <= p.y[1];
		sample.y_third  <= p.y[2];
		sample.y_fourth <= p.y[3];
		sample.query_x  <= p.q;
		// hold the item until it is taken
		do @(posedge clk); while (!sample.ready);
	endtask

	// Stimulus: directed table first, then random bursts separated by gaps.
	initial begin
		vector_t   directed [$];
		res_t      r;
		int        burst_left;
		int        gap;
		localparam logic [31:0] ONE = 32'h0001_0000;
		localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
		localparam logic [31:0] MINV = 32'h8000_0000;

		sample.valid <= 1'b0;
		sample.x_first <= '0; sample.x_second <= '0; sample.x_third <= '0;
		sample.x_fourth <= '0; sample.y_first <= '0; sample.y_second <= '0;
		sample.y_third <= '0; sample.y_fourth <= '0; sample.query_x <= '0;

		// all zero: every denominator vanishes
		directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '{32'h0, 32'h0, 1'b1}));
		// flat ordinates give a flat cubic with no correction
		directed.push_back(row(0, ONE, 2 * ONE, 3 * ONE, 32'h0003_8000, 32'h0003_8000,
			32'h0003_8000, 32'h0003_8000, 32'h0001_8000, 1'b1, '{32'h0003_8000, 32'h0, 1'b0}));
		directed.push_back(row(0, ONE, 2 * ONE, 3 * ONE, MAXV, MAXV, MAXV, MAXV,
			ONE, 1'b1, '{MAXV, 32'h0, 1'b0}));
		directed.push_back(row(0, ONE, 2 * ONE, 3 * ONE, MINV, MINV, MINV, MINV,
			3 * ONE, 1'b1, '{MINV, 32'h0, 1'b0}));
		// the rest is checked against the predictor
		directed.push_back(row(0, ONE, 2 * ONE, 3 * ONE, 0, ONE, 2 * ONE, 3 * ONE, 32'h0001_4000));
		directed.push_back(row(0, ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 9 * ONE, 32'h0002_C000));
		directed.push_back(row(MINV, 32'hFFFF_FFFF, 0, MAXV, ONE, MAXV, MINV, 5, 0));
		directed.push_back(row(MINV, 32'hFFFF_FFFF, 0, MAXV, MAXV, MINV, MAXV, MINV, MINV));
		directed.push_back(row(MINV, 32'hFFFF_FFFF, 0, MAXV, 7, 8, 9, 10, MAXV));
		directed.push_back(row(0, 2 * ONE, 4 * ONE, 6 * ONE, ONE, 5 * ONE, 2 * ONE, 0, ONE));
		directed.push_back(row(0, 2 * ONE, 4 * ONE, 6 * ONE, 0, 3 * ONE, ONE, 8, 5 * ONE));
		directed.push_back(row(0, ONE, ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, ONE));
		directed.push_back(row(ONE, ONE, ONE, ONE, 11, 22, 33, 44, 0));
		directed.push_back(row(MAXV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV, 0));
		directed.push_back(row(0, 1, 2, 3, MAXV, MINV, MAXV, MINV, 32'h0000_0064));
		directed.push_back(row(0, 1, 2, 3, MINV, MAXV, MINV, MAXV, 32'hFFFF_FF00));
		directed.push_back(row(3 * ONE, 2 * ONE, ONE, 0, 9, 4, 1, 0, 32'h0000_8000));
		directed.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFC,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) begin
			r = directed[i].known ? directed[i].res : interpolate(directed[i].pts);
			drive(directed[i].pts);
			expected_q.push_back(r);
		end

		burst_left = $urandom_range(1, 40);
		for (int n = 0; n < N_RANDOM; n++) begin
			point_set_t p;
			if (burst_left == 0) begin
				sample.valid <= 1'b0;
				gap = $urandom_range(1, 12);
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 60);
			end
			// once midway, hold off until the pipeline has fully drained
			if (n == N_RANDOM / 2) begin
				sample.valid <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end
			p = random_set();
			r = interpolate(p);
			drive(p);
			expected_q.push_back(r);
			burst_left--;
		end
		sample.valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: stalls of random length, with long stretches of steady ready.
	int stall_left = 0;
	int cycle_count = 0;

	always @(posedge clk) begin
		res_t want;
		cycle_count <= cycle_count + 1;
		if (result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (result.interp_value !== want.interp_value) begin
					$error("interp_value: expected %h, got %h", want.interp_value,
						result.interp_value);
					errors++;
				end
				if (result.error_estimate !== want.error_estimate) begin
					$error("error_estimate: expected %h, got %h", want.error_estimate,
						result.error_estimate);
					errors++;
				end
				if (result.coincident_flag !== want.coincident_flag) begin
					$error("coincident_flag: expected %b, got %b", want.coincident_flag,
						result.coincident_flag);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result.ready <= 1'b1;
			// new stalls start only in every other window of cycle_count (bit 9 set)
			if (cycle_count[9] && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 20);
		end
	end

	// Watchdog: count cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> neville_four_point_interpolator.f
rtl/nfpi_pkg.sv
rtl/nfpi_sample_if.sv
rtl/nfpi_result_if.sv
rtl/nfpi_div.sv
rtl/nfpi_lane.sv
rtl/nfpi_level.sv
rtl/neville_four_point_interpolator.sv
tb/neville_four_point_interpolator_tb.sv
